// ----- src/rfb_pkg.sv -----
// rfb_pkg: shared codes for the remote framebuffer stream parser
// no dependencies
`default_nettype none
package rfb_pkg;
	localparam logic [2:0] KIND_VERSION  = 3'd0;
	localparam logic [2:0] KIND_SEC_NONE = 3'd1;
	localparam logic [2:0] KIND_CL_INIT  = 3'd2;
	localparam logic [2:0] KIND_READY    = 3'd3;
	localparam logic [2:0] KIND_PIXEL    = 3'd4;
	localparam logic [2:0] KIND_FRAME    = 3'd5;
	localparam logic [2:0] KIND_EMPTY    = 3'd6;
	localparam logic [2:0] KIND_FAIL     = 3'd7;

	localparam logic [2:0] FR_REFUSED  = 3'd0;
	localparam logic [2:0] FR_AUTH     = 3'd1;
	localparam logic [2:0] FR_GEOMETRY = 3'd2;
	localparam logic [2:0] FR_PROTOCOL = 3'd3;
	localparam logic [2:0] FR_ENCODING = 3'd4;

	localparam logic CMD_BYTE    = 1'b0;
	localparam logic CMD_RESTART = 1'b1;

	typedef struct packed {
		logic [2:0]  kind;
		logic [23:0] pixel_address;
		logic [31:0] pixel_value;
		logic [12:0] screen_width;
		logic [12:0] screen_height;
		logic [2:0]  fail_reason;
	} result_t;
endpackage
`default_nettype wire

// ----- src/rfb_client_stream_parser.sv -----
// rfb_client_stream_parser: byte-serial parser for the server-to-client
// stream of a raw-encoding remote framebuffer session; uses rfb_pkg
//
// usage: one beat on the input channel carries a command (received byte or
// restart) and a byte. each beat yields zero, one or two result beats on the
// output channel; last marks the final result of a byte. a byte is parsed
// in the cycle it is taken; its results sit in a two-entry queue and leave
// one per cycle while the receiver does not stall.
// throughput: one byte per cycle while each byte makes at most one result
// and the receiver does not stall; a byte that makes two results holds the
// input back while the result queue drains one entry a cycle.
// pixel addresses come from an address register that steps by one along a row and
// by the screen width per row; y times width is summed from partial products.
// reset clears the parser to the version phase and empties the queue.
// when the receiver stalls, results stay in the queue; the input stalls only
// when the queue cannot take the results of another byte.
`default_nettype none
module rfb_client_stream_parser #(
	parameter int MAX_DIM = 4096
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_stall,
	input  wire  [0:0]  command,
	input  wire  [7:0]  rx_byte,
	output logic        out_valid,
	input  wire         out_stall,
	output logic [2:0]  kind,
	output logic [23:0] pixel_address,
	output logic [31:0] pixel_value,
	output logic [12:0] screen_width,
	output logic [12:0] screen_height,
	output logic [2:0]  fail_reason,
	output logic        last
);
	import rfb_pkg::*;

	localparam logic [2:0] PH_VERSION = 3'd0;
	localparam logic [2:0] PH_SECTYPES = 3'd1;
	localparam logic [2:0] PH_SECRESULT = 3'd2;
	localparam logic [2:0] PH_SERVERINIT = 3'd3;
	localparam logic [2:0] PH_NORMAL = 3'd4;
	localparam logic [1:0] MS_TYPE = 2'd0;
	localparam logic [1:0] MS_FBU_HEAD = 2'd1;
	localparam logic [1:0] MS_RECT_HEAD = 2'd2;
	localparam logic [1:0] MS_RECT_DATA = 2'd3;

	// parser state
	logic [2:0]  phase_q;
	logic [1:0]  mstate_q;
	logic [4:0]  fcnt_q;
	logic [63:0] hdr_q;
	logic [32:0] skip_q;
	logic [15:0] width_q, height_q, rects_q;
	logic [15:0] rx_q, ry_q, rw_q, rh_q;
	logic        inside_q, failed_q;
	logic [23:0] acc_q;
	logic [15:0] col_q, row_q;
	logic [23:0] addr_q;     // address of the current pixel
	logic [23:0] rowbase_q;  // address of the current row start

	// result queue, two entries
	result_t     qd_q [2];
	logic        ql_q [2];
	logic [1:0]  qn_q;

	logic [2:0]  phase_d;
	logic [1:0]  mstate_d;
	logic [4:0]  fcnt_d;
	logic [63:0] hdr_d;
	logic [32:0] skip_d;
	logic [15:0] width_d, height_d, rects_d, rx_d, ry_d, rw_d, rh_d, col_d, row_d;
	logic        inside_d, failed_d;
	logic [23:0] acc_d, addr_d, rowbase_d;
	result_t     r0, r1;
	logic [1:0]  nres;

	logic        take;
	logic        pop;
	logic [4:0]  fc1;
	logic [63:0] hsh;
	logic [7:0]  mtype;
	logic [16:0] rect_end_x;

	assign pop  = out_valid && !out_stall;
	// accept only when the queue can hold two more results after this cycle
	assign in_stall = (qn_q == 2'd2) || (qn_q == 2'd1 && !pop);
	assign take = in_valid && !in_stall;
	assign fc1 = fcnt_q + 5'd1;
	assign hsh = {hdr_q[55:0], rx_byte};
	assign rect_end_x = {1'b0, rx_q} + {1'b0, rw_q};

	function automatic result_t mk(input logic [2:0] k, input logic [2:0] why);
		result_t r;
		r = '0;
		r.kind = k;
		r.fail_reason = why;
		return r;
	endfunction

	always_comb begin
		phase_d = phase_q; mstate_d = mstate_q; fcnt_d = fcnt_q; hdr_d = hdr_q;
		skip_d = skip_q; width_d = width_q; height_d = height_q; rects_d = rects_q;
		rx_d = rx_q; ry_d = ry_q; rw_d = rw_q; rh_d = rh_q; col_d = col_q;
		row_d = row_q; inside_d = inside_q; failed_d = failed_q; acc_d = acc_q;
		addr_d = addr_q; rowbase_d = rowbase_q;
		r0 = '0; r1 = '0; nres = 2'd0;
		mtype = hsh[{fcnt_q[2:0], 3'b000} +: 8];
		if (command == CMD_RESTART) begin
			phase_d = PH_VERSION; mstate_d = MS_TYPE; fcnt_d = '0; hdr_d = '0;
			skip_d = '0; width_d = '0; height_d = '0; rects_d = '0; rx_d = '0;
			ry_d = '0; rw_d = '0; rh_d = '0; col_d = '0; row_d = '0;
			inside_d = 1'b0; failed_d = 1'b0; acc_d = '0;
		end else if (!failed_q) begin
			unique case (phase_q)
				PH_VERSION: begin
					fcnt_d = fc1;
					if (fc1 >= 5'd12) begin
						fcnt_d = '0; r0 = mk(KIND_VERSION, '0); nres = 2'd1;
						phase_d = PH_SECTYPES;
					end
				end
				PH_SECTYPES: begin
					if (fcnt_q == 5'd0) begin
						if (rx_byte == 8'd0) begin
							failed_d = 1'b1; r0 = mk(KIND_FAIL, FR_REFUSED); nres = 2'd1;
						end else begin
							skip_d = {25'd0, rx_byte}; fcnt_d = 5'd1;
						end
					end else begin
						if (skip_q != '0) skip_d = skip_q - 33'd1;
						if (skip_d == '0) begin
							fcnt_d = '0; hdr_d = '0; r0 = mk(KIND_SEC_NONE, '0);
							nres = 2'd1; phase_d = PH_SECRESULT;
						end
					end
				end
				PH_SECRESULT: begin
					hdr_d = hsh; fcnt_d = fc1;
					if (fc1 >= 5'd4) begin
						fcnt_d = '0;
						if (hsh[31:0] != '0) begin
							failed_d = 1'b1; r0 = mk(KIND_FAIL, FR_AUTH); nres = 2'd1;
						end else begin
							hdr_d = '0; r0 = mk(KIND_CL_INIT, '0); nres = 2'd1;
							phase_d = PH_SERVERINIT;
						end
					end
				end
				PH_SERVERINIT: begin
					logic fin;
					fin = 1'b0;
					if (fcnt_q < 5'd24) begin
						hdr_d = hsh; fcnt_d = fc1;
						if (fc1 == 5'd2) width_d = hsh[15:0];
						else if (fc1 == 5'd4) height_d = hsh[15:0];
						else if (fc1 == 5'd24) begin
							skip_d = {1'b0, hsh[31:0]};
							fin = (hsh[31:0] == '0);
						end
					end else begin
						if (skip_q != '0) skip_d = skip_q - 33'd1;
						fin = (skip_d == '0);
					end
					if (fin) begin
						fcnt_d = '0; hdr_d = '0; skip_d = '0;
						if (width_q == '0 || height_q == '0 ||
						    32'(width_q) > MAX_DIM || 32'(height_q) > MAX_DIM) begin
							failed_d = 1'b1; r0 = mk(KIND_FAIL, FR_GEOMETRY); nres = 2'd1;
						end else begin
							r0 = mk(KIND_READY, '0);
							r0.screen_width = width_q[12:0];
							r0.screen_height = height_q[12:0];
							nres = 2'd1; phase_d = PH_NORMAL; mstate_d = MS_TYPE;
						end
					end
				end
				default: begin
					unique case (mstate_q)
						MS_TYPE: begin
							if (skip_q != '0) skip_d = skip_q - 33'd1;
							else if (fcnt_q == 5'd0) begin
								hdr_d = '0;
								if (rx_byte == 8'd0) mstate_d = MS_FBU_HEAD;
								else if (rx_byte == 8'd2) begin
								end else if (rx_byte == 8'd1 || rx_byte == 8'd3) begin
									hdr_d = {56'd0, rx_byte}; fcnt_d = 5'd1;
								end else begin
									failed_d = 1'b1; r0 = mk(KIND_FAIL, FR_PROTOCOL);
									nres = 2'd1;
								end
							end else begin
								hdr_d = hsh; fcnt_d = fc1;
								// type byte now sits fcnt_q bytes above the new byte
								if (mtype == 8'd1 && fc1 >= 5'd6) begin
									skip_d = 33'({17'd0, hsh[15:0]} * 33'd6); fcnt_d = '0;
								end else if (mtype == 8'd3 && fc1 >= 5'd8) begin
									skip_d = {1'b0, hsh[31:0]}; fcnt_d = '0;
								end
							end
						end
						MS_FBU_HEAD: begin
							hdr_d = hsh; fcnt_d = fc1;
							if (fc1 >= 5'd3) begin
								rects_d = hsh[15:0]; fcnt_d = '0;
								if (hsh[15:0] == '0) begin
									r0 = mk(KIND_EMPTY, '0); nres = 2'd1; mstate_d = MS_TYPE;
								end else mstate_d = MS_RECT_HEAD;
							end
						end
						MS_RECT_HEAD: begin
							hdr_d = hsh; fcnt_d = fc1;
							if (fc1 == 5'd2) rx_d = hsh[15:0];
							else if (fc1 == 5'd4) begin
								ry_d = hsh[15:0];
								rowbase_d = '0;
								col_d = '0; // column counter cleared; y*width is built in rowbase from ry below
								row_d = hsh[15:0];
							end else if (fc1 == 5'd6) rw_d = hsh[15:0];
							else if (fc1 == 5'd8) rh_d = hsh[15:0];
							else if (fc1 >= 5'd12) begin
								fcnt_d = '0;
								if (hsh[31:0] != '0) begin
									failed_d = 1'b1; r0 = mk(KIND_FAIL, FR_ENCODING);
									nres = 2'd1;
								end else begin
									inside_d = (rect_end_x <= {1'b0, width_q}) &&
									    ({1'b0, ry_q} + {1'b0, rh_q} <= {1'b0, height_q});
									col_d = '0; row_d = '0; acc_d = '0;
									addr_d = rowbase_q + 24'(rx_q);
									if (rw_q == '0 || rh_q == '0) begin
										rects_d = rects_q - 16'd1;
										if (rects_q != 16'd1) mstate_d = MS_RECT_HEAD;
										else begin
											r0 = mk(KIND_FRAME, '0); nres = 2'd1;
											mstate_d = MS_TYPE;
										end
									end else mstate_d = MS_RECT_DATA;
								end
							end
							// between y and the end of the header, add one partial product of y and width
							// per byte; y arrives with at least 8 header bytes left
							if (fc1 > 5'd4 && fc1 < 5'd12) begin
								// each byte adds two or four bits of y times width, shifted to their weight,
								// so rowbase holds y*width by the end of the header as a bounded shift-add
								logic [15:0] yv;
								yv = ry_q;
								unique case (fc1)
									5'd5: rowbase_d = 24'(width_q) * 24'(yv[1:0]);
									5'd6: rowbase_d = rowbase_q + 24'({yv[3:2], 2'b00} * 18'(width_q));
									5'd7: rowbase_d = rowbase_q + 24'({yv[5:4], 4'b0} * 22'(width_q));
									5'd8: rowbase_d = rowbase_q + 24'({yv[7:6], 6'b0} * 24'(width_q));
									5'd9: rowbase_d = rowbase_q + 24'(({yv[11:8]} * 24'(width_q)) << 8);
									5'd10: rowbase_d = rowbase_q + 24'(({yv[15:12]} * 24'(width_q)) << 12);
									default: rowbase_d = rowbase_q;
								endcase
							end
						end
						default: begin
							if (fcnt_q < 5'd3) begin
								acc_d = {acc_q[15:0], rx_byte}; fcnt_d = fc1;
							end else begin
								fcnt_d = '0; acc_d = '0;
								if (inside_q) begin
									r0 = mk(KIND_PIXEL, '0);
									r0.pixel_address = addr_q;
									r0.pixel_value = {acc_q, rx_byte};
									nres = 2'd1;
								end
								col_d = col_q + 16'd1; addr_d = addr_q + 24'd1;
								if (col_d >= rw_q) begin
									col_d = '0; row_d = row_q + 16'd1;
									rowbase_d = rowbase_q + 24'(width_q);
									addr_d = rowbase_q + 24'(width_q) + 24'(rx_q);
									if (row_d >= rh_q) begin
										rects_d = rects_q - 16'd1;
										col_d = '0; row_d = '0; acc_d = '0;
										if (rects_q != 16'd1) mstate_d = MS_RECT_HEAD;
										else begin
											if (nres == 2'd1) begin
												r1 = mk(KIND_FRAME, '0); nres = 2'd2;
											end else begin
												r0 = mk(KIND_FRAME, '0); nres = 2'd1;
											end
											mstate_d = MS_TYPE;
										end
									end
								end
							end
						end
					endcase
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_VERSION; mstate_q <= MS_TYPE; fcnt_q <= '0; hdr_q <= '0;
			skip_q <= '0; width_q <= '0; height_q <= '0; rects_q <= '0;
			rx_q <= '0; ry_q <= '0; rw_q <= '0; rh_q <= '0; col_q <= '0;
			row_q <= '0; inside_q <= 1'b0; failed_q <= 1'b0; acc_q <= '0;
			addr_q <= '0; rowbase_q <= '0; qn_q <= '0;
		end else begin
			logic [1:0] n;
			result_t    d0, d1;
			logic       l0, l1;
			n = qn_q;
			d0 = qd_q[0]; d1 = qd_q[1]; l0 = ql_q[0]; l1 = ql_q[1];
			if (pop) begin
				d0 = d1; l0 = l1; n = n - 2'd1;
			end
			if (take) begin
				phase_q <= phase_d; mstate_q <= mstate_d; fcnt_q <= fcnt_d;
				hdr_q <= hdr_d; skip_q <= skip_d; width_q <= width_d;
				height_q <= height_d; rects_q <= rects_d; rx_q <= rx_d; ry_q <= ry_d;
				rw_q <= rw_d; rh_q <= rh_d; col_q <= col_d; row_q <= row_d;
				inside_q <= inside_d; failed_q <= failed_d; acc_q <= acc_d;
				addr_q <= addr_d; rowbase_q <= rowbase_d;
				if (nres != 2'd0) begin
					if (n[0]) begin
						d1 = r0; l1 = (nres == 2'd1);
					end else begin
						d0 = r0; l0 = (nres == 2'd1);
					end
				end
				if (nres == 2'd2) begin
					d1 = r1; l1 = 1'b1;
				end
				n = n + nres;
			end
			qd_q[0] <= d0; qd_q[1] <= d1;
			ql_q[0] <= l0; ql_q[1] <= l1;
			qn_q <= n;
		end
	end

	assign out_valid = (qn_q != 2'd0);
	assign kind = qd_q[0].kind;
	assign pixel_address = qd_q[0].pixel_address;
	assign pixel_value = qd_q[0].pixel_value;
	assign screen_width = qd_q[0].screen_width;
	assign screen_height = qd_q[0].screen_height;
	assign fail_reason = qd_q[0].fail_reason;
	assign last = ql_q[0];
endmodule
`default_nettype wire

// ----- tb/rfb_client_stream_parser_tb.sv -----
// rfb_client_stream_parser_tb: self-checking bench for the raw-encoding rfb stream parser
// depends on rfb_pkg and rfb_client_stream_parser; a behavioral parser predicts every result
`default_nettype none
module rfb_client_stream_parser_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import rfb_pkg::*;

	localparam int MAX_DIM = 4096;
	localparam int CYCLE_LIMIT = 400000;

	typedef enum logic [2:0] {
		PH_VERSION, PH_SECTYPES, PH_SECRESULT, PH_SERVERINIT, PH_NORMAL
	} phase_e;
	typedef enum logic [1:0] {
		MS_TYPE, MS_FBU_HEAD, MS_RECT_HEAD, MS_RECT_DATA
	} msg_e;

	typedef struct packed {
		logic [2:0]  kind;
		logic [23:0] pixel_address;
		logic [31:0] pixel_value;
		logic [12:0] screen_width;
		logic [12:0] screen_height;
		logic [2:0]  fail_reason;
		logic        last;
	} event_t;

	typedef struct packed {
		logic       cmd;
		logic [7:0] data;
	} beat_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [0:0] command = CMD_BYTE;
	logic [7:0] rx_byte = 8'd0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [2:0] kind;
	logic [23:0] pixel_address;
	logic [31:0] pixel_value;
	logic [12:0] screen_width;
	logic [12:0] screen_height;
	logic [2:0] fail_reason;
	logic last;

	rfb_client_stream_parser #(.MAX_DIM(MAX_DIM)) i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.command(command), .rx_byte(rx_byte),
		.out_valid(out_valid), .out_stall(out_stall),
		.kind(kind), .pixel_address(pixel_address), .pixel_value(pixel_value),
		.screen_width(screen_width), .screen_height(screen_height),
		.fail_reason(fail_reason), .last(last)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// stimulus plumbing and bookkeeping
	beat_t  pending_bytes[$];
	event_t expected_events[$];
	int     error_count = 0;
	int     cycle_count = 0;
	int     send_idle_pct = 34;
	int     recv_idle_pct = 34;
	int     recv_holdoff = 0;

	// shadow copy of the parser state
	phase_e      sh_phase;
	msg_e        sh_msg;
	logic [4:0]  sh_fcount;
	logic [63:0] sh_header;
	logic [32:0] sh_skip;
	logic [15:0] sh_width, sh_height, sh_rects;
	logic [15:0] sh_rx, sh_ry, sh_rw, sh_rh;
	logic        sh_inside;
	logic [23:0] sh_accum;
	logic [15:0] sh_col, sh_row;
	logic        sh_failed;
	event_t      step_events[$];

	task automatic report_mismatch(input string what);
		$display("mismatch @%0t: %s", $realtime, what);
		error_count++;
	endtask

	function automatic void clear_parser();
		sh_phase = PH_VERSION; sh_msg = MS_TYPE; sh_fcount = '0; sh_header = '0;
		sh_skip = '0; sh_width = '0; sh_height = '0; sh_rects = '0;
		sh_rx = '0; sh_ry = '0; sh_rw = '0; sh_rh = '0; sh_inside = 0;
		sh_accum = '0; sh_col = '0; sh_row = '0; sh_failed = 0;
	endfunction

	function automatic void push_event(logic [2:0] k, logic [23:0] a, logic [31:0] v,
			logic [12:0] w, logic [12:0] h, logic [2:0] r);
		event_t e;
		e = '{k, a, v, w, h, r, 1'b0};
		step_events.push_back(e);
	endfunction

	function automatic void push_fail(logic [2:0] r);
		sh_failed = 1;
		push_event(KIND_FAIL, '0, '0, '0, '0, r);
	endfunction

	function automatic void shift_byte(logic [7:0] b);
		sh_header = {sh_header[55:0], b};
		sh_fcount = sh_fcount + 5'd1;
	endfunction

	function automatic void end_server_init();
		sh_fcount = '0; sh_header = '0; sh_skip = '0;
		if (sh_width == 0 || sh_height == 0 || sh_width > MAX_DIM || sh_height > MAX_DIM)
			push_fail(FR_GEOMETRY);
		else begin
			push_event(KIND_READY, '0, '0, sh_width[12:0], sh_height[12:0], '0);
			sh_phase = PH_NORMAL;
			sh_msg = MS_TYPE;
		end
	endfunction

	function automatic void end_rect();
		sh_rects = sh_rects - 16'd1;
		sh_col = '0; sh_row = '0; sh_fcount = '0; sh_accum = '0;
		if (sh_rects != 0)
			sh_msg = MS_RECT_HEAD;
		else begin
			push_event(KIND_FRAME, '0, '0, '0, '0, '0);
			sh_msg = MS_TYPE;
		end
	endfunction

	// normal-phase message parsing
	function automatic void parse_message_byte(logic [7:0] b);
		logic [7:0]  msg_type;
		logic [47:0] addr;
		case (sh_msg)
		MS_TYPE: begin
			if (sh_skip != 0) begin
				sh_skip = sh_skip - 33'd1;
				return;
			end
			if (sh_fcount == 0) begin
				sh_header = '0;
				if (b == 8'd0) sh_msg = MS_FBU_HEAD;
				else if (b == 8'd2) ;
				else if (b == 8'd1 || b == 8'd3) shift_byte(b);
				else push_fail(FR_PROTOCOL);
				return;
			end
			shift_byte(b);
			msg_type = 8'(sh_header >> (8 * ((sh_fcount - 5'd1) & 5'd7)));
			if (msg_type == 8'd1 && sh_fcount >= 6) begin
				sh_skip = 33'(sh_header[15:0]) * 33'd6;
				sh_fcount = '0;
			end else if (msg_type == 8'd3 && sh_fcount >= 8) begin
				sh_skip = 33'(sh_header[31:0]);
				sh_fcount = '0;
			end
		end
		MS_FBU_HEAD: begin
			shift_byte(b);
			if (sh_fcount >= 3) begin
				sh_rects = sh_header[15:0];
				sh_fcount = '0;
				if (sh_rects == 0) begin
					push_event(KIND_EMPTY, '0, '0, '0, '0, '0);
					sh_msg = MS_TYPE;
				end else sh_msg = MS_RECT_HEAD;
			end
		end
		MS_RECT_HEAD: begin
			shift_byte(b);
			if (sh_fcount == 2) sh_rx = sh_header[15:0];
			else if (sh_fcount == 4) sh_ry = sh_header[15:0];
			else if (sh_fcount == 6) sh_rw = sh_header[15:0];
			else if (sh_fcount == 8) sh_rh = sh_header[15:0];
			else if (sh_fcount >= 12) begin
				sh_fcount = '0;
				if (sh_header[31:0] != 0) begin
					push_fail(FR_ENCODING);
					return;
				end
				sh_inside = (17'(sh_rx) + 17'(sh_rw) <= 17'(sh_width)) &&
					(17'(sh_ry) + 17'(sh_rh) <= 17'(sh_height));
				sh_col = '0; sh_row = '0; sh_accum = '0;
				if (sh_rw == 0 || sh_rh == 0) end_rect();
				else sh_msg = MS_RECT_DATA;
			end
		end
		default: begin
			if (sh_fcount < 3) begin
				sh_accum = {sh_accum[15:0], b};
				sh_fcount = sh_fcount + 5'd1;
				return;
			end
			sh_fcount = '0;
			if (sh_inside) begin
				addr = (48'(sh_ry) + 48'(sh_row)) * 48'(sh_width) + 48'(sh_rx) + 48'(sh_col);
				push_event(KIND_PIXEL, addr[23:0], {sh_accum, b}, '0, '0, '0);
			end
			sh_accum = '0;
			sh_col = sh_col + 16'd1;
			if (sh_col >= sh_rw) begin
				sh_col = '0;
				sh_row = sh_row + 16'd1;
				if (sh_row >= sh_rh) end_rect();
			end
		end
		endcase
	endfunction

	// predict the result beats of one accepted input beat
	function automatic void predict_events(beat_t in_beat);
		logic [7:0] b;
		b = in_beat.data;
		step_events.delete();
		if (in_beat.cmd == CMD_RESTART) begin
			clear_parser();
			return;
		end
		if (sh_failed) return;
		case (sh_phase)
		PH_VERSION: begin
			sh_fcount = sh_fcount + 5'd1;
			if (sh_fcount >= 12) begin
				sh_fcount = '0;
				push_event(KIND_VERSION, '0, '0, '0, '0, '0);
				sh_phase = PH_SECTYPES;
			end
		end
		PH_SECTYPES: begin
			if (sh_fcount == 0) begin
				if (b == 0) push_fail(FR_REFUSED);
				else begin
					sh_skip = 33'(b);
					sh_fcount = 5'd1;
				end
			end else begin
				if (sh_skip != 0) sh_skip = sh_skip - 33'd1;
				if (sh_skip == 0) begin
					sh_fcount = '0; sh_header = '0;
					push_event(KIND_SEC_NONE, '0, '0, '0, '0, '0);
					sh_phase = PH_SECRESULT;
				end
			end
		end
		PH_SECRESULT: begin
			shift_byte(b);
			if (sh_fcount >= 4) begin
				sh_fcount = '0;
				if (sh_header[31:0] != 0) push_fail(FR_AUTH);
				else begin
					sh_header = '0;
					push_event(KIND_CL_INIT, '0, '0, '0, '0, '0);
					sh_phase = PH_SERVERINIT;
				end
			end
		end
		PH_SERVERINIT: begin
			if (sh_fcount < 24) begin
				shift_byte(b);
				if (sh_fcount == 2) sh_width = sh_header[15:0];
				else if (sh_fcount == 4) sh_height = sh_header[15:0];
				else if (sh_fcount == 24) begin
					sh_skip = 33'(sh_header[31:0]);
					if (sh_skip == 0) end_server_init();
				end
			end else begin
				if (sh_skip != 0) sh_skip = sh_skip - 33'd1;
				if (sh_skip == 0) end_server_init();
			end
		end
		default: parse_message_byte(b);
		endcase
		if (step_events.size() > 0) step_events[step_events.size() - 1].last = 1'b1;
		foreach (step_events[i]) expected_events.push_back(step_events[i]);
	endfunction

	// stimulus builders
	task automatic put_byte(input logic [7:0] b);
		pending_bytes.push_back('{CMD_BYTE, b});
	endtask

	task automatic put_be(input logic [31:0] v, input int n);
		for (int i = n - 1; i >= 0; i--) put_byte(v[8 * i +: 8]);
	endtask

	task automatic put_restart();
		pending_bytes.push_back('{CMD_RESTART, 8'($urandom)});
	endtask

	// full handshake with a chosen geometry and a short server name
	task automatic put_handshake(input logic [15:0] w, input logic [15:0] h, input int name_len);
		put_restart();
		for (int i = 0; i < 12; i++) put_byte(8'($urandom));
		put_byte(8'd1);
		put_byte(8'($urandom));
		put_be(32'd0, 4);
		put_be(w, 2);
		put_be(h, 2);
		for (int i = 0; i < 16; i++) put_byte(8'($urandom));
		put_be(name_len, 4);
		for (int i = 0; i < name_len; i++) put_byte(8'($urandom));
	endtask

	// framebuffer update: raw rectangles inside or near the screen, rarely far off or non-raw
	task automatic put_update(input int w, input int h, input int nrects);
		int rx, ry, rw, rh, enc;
		put_byte(8'd0);
		put_byte(8'($urandom));
		put_be(nrects, 2);
		for (int r = 0; r < nrects; r++) begin
			rw = $urandom_range(0, 3);
			rh = $urandom_range(0, 3);
			rx = $urandom_range(0, w + 1);
			ry = $urandom_range(0, h + 1);
			if ($urandom_range(0, 29) == 0) begin
				rx = 16'hffff - $urandom_range(0, 2);
				ry = $urandom_range(0, 1) ? 16'hffff : 0;
			end
			enc = ($urandom_range(0, 39) == 0) ? $urandom : 0;
			put_be(rx, 2); put_be(ry, 2); put_be(rw, 2); put_be(rh, 2);
			put_be(enc, 4);
			if (enc != 0) return;
			for (int p = 0; p < rw * rh * 4; p++) put_byte(8'($urandom));
		end
	endtask

	// driver: one beat offered from the queue, held while stalled
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) predict_events('{command, rx_byte});
			if ((!in_valid || !in_stall)) begin
				if (pending_bytes.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
					beat_t nb;
					nb = pending_bytes.pop_front();
					in_valid <= 1'b1;
					command <= nb.cmd;
					rx_byte <= nb.data;
				end else in_valid <= 1'b0;
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_events.size() == 0)
					report_mismatch($sformatf("unexpected result kind %0d", kind));
				else begin
					event_t e, got;
					e = expected_events.pop_front();
					got = '{kind, pixel_address, pixel_value, screen_width, screen_height,
						fail_reason, last};
					if (got.kind != e.kind) report_mismatch("kind");
					if (got.pixel_address != e.pixel_address) report_mismatch("pixel_address");
					if (got.pixel_value != e.pixel_value) report_mismatch("pixel_value");
					if (got.screen_width != e.screen_width) report_mismatch("screen_width");
					if (got.screen_height != e.screen_height) report_mismatch("screen_height");
					if (got.fail_reason != e.fail_reason) report_mismatch("fail_reason");
					if (got.last != e.last) report_mismatch("last");
				end
			end
		end
		if (cycle_count > CYCLE_LIMIT) begin
			$display("rfb_client_stream_parser_tb NOT OK");
			$finish;
		end
	end

	// receiver stall generation, with a counted hold-off stretch
	always @(posedge clk) begin
		if (arst_n) begin
			if (recv_holdoff > 0) begin
				recv_holdoff <= recv_holdoff - 1;
				out_stall <= 1'b1;
			end else out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
		end
	end

	task automatic wait_drained();
		while (pending_bytes.size() > 0 || in_valid || expected_events.size() > 0)
			@(posedge clk);
	endtask

	initial begin
		int w, h;
		clear_parser();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// directed: extremes and each failure path
		put_handshake(16'd4, 16'd3, 0);
		put_update(4, 3, 1);
		put_byte(8'd0); put_byte(8'hff); put_be(0, 2);    // empty update
		put_byte(8'd2);                                 // bell
		put_byte(8'd1); put_byte(8'hff); put_be(16'h0001, 2); put_be(1, 2);
		for (int i = 0; i < 6; i++) put_byte(8'($urandom));
		put_byte(8'd3); put_be(24'hffffff, 3); put_be(5, 4);
		for (int i = 0; i < 5; i++) put_byte(8'hff);
		put_byte(8'd7);                                 // bad message type
		put_byte(8'd0);                                 // ignored after failure
		put_restart();
		for (int i = 0; i < 12; i++) put_byte(8'h55);
		put_byte(8'd0);                                 // no security types
		put_restart();
		for (int i = 0; i < 12; i++) put_byte(8'h00);
		put_byte(8'hff);
		for (int i = 0; i < 255; i++) put_byte(8'($urandom));
		put_be(32'h00000100, 4);                       // auth failed
		put_handshake(16'd0, 16'd5, 0);
		put_handshake(16'd4097, 16'd5, 0);
		put_handshake(16'd4096, 16'd4096, 2);
		put_byte(8'd0); put_byte(8'd0); put_be(1, 2);
		put_be(16'd4095, 2); put_be(16'd4095, 2); put_be(1, 2); put_be(1, 2); put_be(0, 4);
		put_be(32'hffffffff, 4);
		put_byte(8'd0); put_byte(8'd0); put_be(1, 2);
		put_be(0, 2); put_be(0, 2); put_be(2, 2); put_be(2, 2); put_be(32'h80000000, 4);
		wait_drained();

		// sender pauses until every expected result has come, then receiver holds off
		repeat (5) @(posedge clk);
		recv_holdoff = 200;
		put_handshake(16'd5, 16'd4, 1);
		for (int k = 0; k < 4; k++) put_update(5, 4, 2);
		wait_drained();

		// random sessions, one quiet stretch with no idling
		for (int s = 0; s < 2; s++) begin
			if (s == 1) begin send_idle_pct = 0; recv_idle_pct = 0; end
			w = $urandom_range(1, 8);
			h = $urandom_range(1, 8);
			if (s == 0) w = MAX_DIM;
			put_handshake(w, h, $urandom_range(0, 3));
			for (int m = 0; m < 4; m++) begin
				case ($urandom_range(0, 9))
				0: put_byte(8'd2);
				1: begin put_byte(8'd1); put_byte(8'($urandom)); put_be(0, 2); put_be(1, 2);
					for (int i = 0; i < 6; i++) put_byte(8'($urandom)); end
				2: begin put_byte(8'd3); put_be(0, 3); put_be(2, 4);
					put_byte(8'($urandom)); put_byte(8'($urandom)); end
				3: if ($urandom_range(0, 3) == 0) put_byte(8'($urandom_range(4, 255)));
				default: put_update(w, h, $urandom_range(0, 3));
				endcase
			end
			wait_drained();
		end
		send_idle_pct = 34; recv_idle_pct = 34;
		for (int i = 0; i < 20; i++) put_byte(8'($urandom));
		wait_drained();
		repeat (20) @(posedge clk);
		if (error_count == 0)
			$display("rfb_client_stream_parser_tb OK");
		else
			$display("rfb_client_stream_parser_tb NOT OK");
		$finish;
	end
endmodule
`default_nettype wire

// ----- files.f -----
src/rfb_pkg.sv
src/rfb_client_stream_parser.sv
tb/rfb_client_stream_parser_tb.sv
